[design/delimited_frame_receiver_defines.svh]
// ---------------------------------------------------------------------------
// delimited_frame_receiver_defines
// assertion macros shared by the frame receiver checker
// ---------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_DEFINES_SVH

// antecedent implies consequent in the same cycle, ignored while in reset
`define DFR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// antecedent implies consequent in the following cycle, ignored while in reset
`define DFR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

[design/dfr_pkg.sv]
// ---------------------------------------------------------------------------
// dfr_pkg
// types and constants of the delimited frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

    // stream and register port widths
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int ERR_W       = 5;
    localparam int PLEN_W      = 6;
    localparam int TIME_W      = 32;
    localparam int TOUT_W      = 16;

    // commands carried in the input tuser
    typedef enum logic [1:0] {
        OP_FEED   = 2'd0,
        OP_TAKE   = 2'd1,
        OP_PEEK   = 2'd2,
        OP_ERRORS = 2'd3
    } t_opcode;

    // positions of the sticky error flags
    localparam int ERR_MISSED    = 0;
    localparam int ERR_TIMEOUT   = 1;
    localparam int ERR_COLLISION = 2;
    localparam int ERR_BAD_LEN   = 3;
    localparam int ERR_CORRUPT   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ID    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIMEOUT = 8'd3;

    // configuration reset values
    localparam logic [7:0]        RST_START_CHAR   = 8'd2;
    localparam logic [7:0]        RST_END_CHAR     = 8'd3;
    localparam logic [7:0]        RST_MASTER_ID    = 8'd0;
    localparam logic [TOUT_W-1:0] RST_BYTE_TIMEOUT = 16'd10;

    // position inside a frame
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SENDER,
        PH_RECEIVER,
        PH_TYPE,
        PH_LENGTH,
        PH_DATA,
        PH_CRC,
        PH_END
    } t_phase;

    // command sequencer
    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

endpackage

`default_nettype wire

[design/delimited_frame_receiver.sv]
// ---------------------------------------------------------------------------
// delimited_frame_receiver
// parses start/end delimited serial frames and streams the stored frame out
// ---------------------------------------------------------------------------
// Input stream: one command per transfer. tuser holds the command (feed byte,
// take frame, peek frame, read and clear errors), tdata the byte and its
// arrival time in ms. Output stream: result items, tlast on the final result
// of a command, tuser set when the item carries a data byte.
// Configuration: write channel with register index and data, always ready;
// write it only while no command is in flight.
// Feed and read-errors give one result, registered in the cycle after the
// transfer. Take and peek of a stored frame of n data bytes read the payload
// memory one entry per cycle while the output is not stalled and give n
// results; each byte passes the memory read register and then the output
// register. A feed, read-errors or empty readout gives a single result.
// Reset clears the parser, the pending mark, the error flags and loads the
// default configuration; the payload memory is not cleared and is only read
// at entries the pending frame has written.
// When the receiver stalls the output register holds its result and the
// input side stops taking commands until the result has been taken.
`default_nettype none

module delimited_frame_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: rx_byte [7:0], now_ms [39:8]
    input  wire logic [dfr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: opcode [1:0]
    input  wire logic [dfr_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata: frame_ready [0], error_bits [5:1], sender [13:6],
    // receiver [21:14], message_type [29:22], payload_length [35:30],
    // payload_byte [43:36], zero [47:44]
    output logic [dfr_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: payload_valid [0]
    output logic                                 o_m_tuser,
    output logic                                 o_m_tlast,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import dfr_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // configuration registers
    logic [7:0]        r_start_char;
    logic [7:0]        r_end_char;
    logic [7:0]        r_master_id;
    logic [TOUT_W-1:0] r_timeout;

    // parser and frame state
    t_phase            r_phase,       n_phase;
    logic [LEN_W-1:0]  r_byte_count,  n_byte_count;
    logic [TIME_W-1:0] r_last_time,   n_last_time;
    logic              r_pending,     n_pending;
    logic [ERR_W-1:0]  r_errors,      n_errors;
    logic [7:0]        r_sender,      n_sender;
    logic [7:0]        r_receiver,    n_receiver;
    logic [7:0]        r_type,        n_type;
    logic [LEN_W-1:0]  r_length,      n_length;

    // sequencer and readout
    t_state            r_state,       n_state;
    logic [LEN_W-1:0]  r_rd_idx,      n_rd_idx;
    logic [7:0]        r_rdata;
    logic [7:0]        r_payload_mem [MAX_PAYLOAD];

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data,  n_out_data;
    logic                   r_out_user,  n_out_user;
    logic                   r_out_last,  n_out_last;

    // feed results
    t_phase            f_phase;
    t_phase            phase_eff;
    logic              timed_out;
    logic [TIME_W-1:0] gap;
    logic [ERR_W-1:0]  f_errors;
    logic              f_pending;
    logic [7:0]        f_sender;
    logic [7:0]        f_receiver;
    logic [7:0]        f_type;
    logic [LEN_W-1:0]  f_length;
    logic [LEN_W-1:0]  f_byte_count;
    logic [LEN_W-1:0]  cnt_inc;

    // memory access
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // handshake and input fields
    t_opcode           s_opcode;
    logic [7:0]        s_byte;
    logic [TIME_W-1:0] s_now;
    logic              s_accept;
    logic              slot_free;
    logic              last_beat;
    logic              stream_start;

    // pack one result into the output tdata layout
    function automatic logic [OUT_TDATA_W-1:0] pack_result(
        input logic             ready,
        input logic [ERR_W-1:0] errs,
        input logic [7:0]       snd,
        input logic [7:0]       rcv,
        input logic [7:0]       typ,
        input logic [LEN_W-1:0] len,
        input logic [7:0]       data
    );
        logic [LEN_W+PLEN_W-1:0] len_ext;
        logic [PLEN_W-1:0]       len6;
        len_ext = {{PLEN_W{1'b0}}, len};
        len6    = ready ? len_ext[PLEN_W-1:0] : '0;
        return {{OUT_PAD_W{1'b0}}, data, len6,
                ready ? typ : 8'd0, ready ? rcv : 8'd0, ready ? snd : 8'd0,
                errs, ready};
    endfunction

    // input fields and handshake
    assign s_opcode   = t_opcode'(i_s_tuser);
    assign s_byte     = i_s_tdata[7:0];
    assign s_now      = i_s_tdata[IN_TDATA_W-1:8];
    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && slot_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    assign last_beat    = (r_rd_idx == (r_length - LEN_W'(1)));
    assign stream_start = r_pending && (r_length != '0);

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= RST_START_CHAR;
            r_end_char   <= RST_END_CHAR;
            r_master_id  <= RST_MASTER_ID;
            r_timeout    <= RST_BYTE_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_CHAR:   r_start_char <= i_cfg_data[7:0];
                CFG_END_CHAR:     r_end_char   <= i_cfg_data[7:0];
                CFG_MASTER_ID:    r_master_id  <= i_cfg_data[7:0];
                CFG_BYTE_TIMEOUT: r_timeout    <= i_cfg_data[TOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // byte timeout check, then next parser phase
    always_comb begin
        gap       = s_now - r_last_time;
        timed_out = (r_phase != PH_IDLE) && (gap > {{(TIME_W-TOUT_W){1'b0}}, r_timeout});
        phase_eff = timed_out ? PH_IDLE : r_phase;
        cnt_inc   = r_byte_count + LEN_W'(1);
        f_phase   = phase_eff;
        unique case (phase_eff)
            PH_IDLE:     if (s_byte == r_start_char) f_phase = PH_SENDER;
            PH_SENDER:   f_phase = PH_RECEIVER;
            PH_RECEIVER: f_phase = PH_TYPE;
            PH_TYPE:     f_phase = PH_LENGTH;
            PH_LENGTH: begin
                if (s_byte > 8'(MAX_PAYLOAD))
                    f_phase = PH_IDLE;
                else if (s_byte == 8'd0)
                    f_phase = PH_CRC;
                else
                    f_phase = PH_DATA;
            end
            PH_DATA:     if (cnt_inc >= r_length) f_phase = PH_CRC;
            PH_CRC:      f_phase = PH_END;
            PH_END:      f_phase = PH_IDLE;
            default:     f_phase = PH_IDLE;
        endcase
    end

    // parser actions on a fed byte
    always_comb begin
        f_errors     = r_errors;
        f_pending    = r_pending;
        f_sender     = r_sender;
        f_receiver   = r_receiver;
        f_type       = r_type;
        f_length     = r_length;
        f_byte_count = r_byte_count;
        mem_waddr    = r_byte_count[AW-1:0];
        mem_we       = 1'b0;
        if (r_pending) f_errors[ERR_MISSED] = 1'b1;
        if (timed_out) f_errors[ERR_TIMEOUT] = 1'b1;
        unique case (phase_eff)
            PH_IDLE: begin
                if (s_byte == r_start_char) begin
                    f_byte_count = '0;
                    f_pending    = 1'b0;
                end
            end
            PH_SENDER: begin
                if (s_byte == r_master_id) begin
                    f_sender = s_byte;
                    f_errors[ERR_COLLISION] = 1'b1;
                end else begin
                    f_sender = s_byte - 8'd1;
                end
            end
            PH_RECEIVER: f_receiver = s_byte;
            PH_TYPE:     f_type = s_byte;
            PH_LENGTH: begin
                if (s_byte > 8'(MAX_PAYLOAD))
                    f_errors[ERR_BAD_LEN] = 1'b1;
                else
                    f_length = s_byte[LEN_W-1:0];
            end
            PH_DATA: begin
                mem_we       = s_accept && (s_opcode == OP_FEED);
                f_byte_count = cnt_inc;
            end
            PH_CRC: ;
            PH_END: begin
                if (s_byte == r_end_char)
                    f_pending = 1'b1;
                else
                    f_errors[ERR_CORRUPT] = 1'b1;
            end
            default: ;
        endcase
    end

    // state updates per accepted command
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_last_time  = r_last_time;
        n_pending    = r_pending;
        n_errors     = r_errors;
        n_sender     = r_sender;
        n_receiver   = r_receiver;
        n_type       = r_type;
        n_length     = r_length;
        if (s_accept) begin
            unique case (s_opcode)
                OP_FEED: begin
                    n_phase      = f_phase;
                    n_byte_count = f_byte_count;
                    n_last_time  = (f_phase != PH_IDLE) ? s_now : r_last_time;
                    n_pending    = f_pending;
                    n_errors     = f_errors;
                    n_sender     = f_sender;
                    n_receiver   = f_receiver;
                    n_type       = f_type;
                    n_length     = f_length;
                end
                OP_TAKE:   n_pending = 1'b0;
                OP_PEEK:   ;
                OP_ERRORS: n_errors = '0;
                default:   ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && ((s_opcode == OP_TAKE) || (s_opcode == OP_PEEK))
                    && stream_start)
                    n_state = ST_STREAM;
            end
            ST_STREAM: begin
                if (slot_free && last_beat) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: result register loads and payload reads
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        n_rd_idx    = r_rd_idx;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_opcode) inside
                        OP_FEED: begin
                            n_out_valid = 1'b1;
                            n_out_data  = pack_result(f_pending, f_errors, f_sender,
                                                      f_receiver, f_type, f_length, 8'd0);
                            n_out_user  = 1'b0;
                            n_out_last  = 1'b1;
                        end
                        OP_TAKE, OP_PEEK: begin
                            if (stream_start) begin
                                // first payload entry, data arrives next cycle
                                mem_re   = 1'b1;
                                n_rd_idx = '0;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_data  = pack_result(r_pending, r_errors, r_sender,
                                                          r_receiver, r_type, r_length, 8'd0);
                                n_out_user  = 1'b0;
                                n_out_last  = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_data  = pack_result(r_pending, r_errors, r_sender,
                                                      r_receiver, r_type, r_length, 8'd0);
                            n_out_user  = 1'b0;
                            n_out_last  = 1'b1;
                        end
                    endcase
                end
            end
            ST_STREAM: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = pack_result(1'b1, r_errors, r_sender, r_receiver,
                                              r_type, r_length, r_rdata);
                    n_out_user  = 1'b1;
                    n_out_last  = last_beat;
                    if (!last_beat) begin
                        mem_re    = 1'b1;
                        n_rd_idx  = r_rd_idx + LEN_W'(1);
                        mem_raddr = n_rd_idx[AW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // payload memory: writes only while parsing, reads only for a take or peek readout
    always_ff @(posedge i_clk) begin
        if (mem_we) r_payload_mem[mem_waddr] <= s_byte;
        if (mem_re) r_rdata <= r_payload_mem[mem_raddr];
    end

    // control and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_last_time  <= '0;
            r_pending    <= 1'b0;
            r_errors     <= '0;
            r_sender     <= '0;
            r_receiver   <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_state      <= ST_IDLE;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_last_time  <= n_last_time;
            r_pending    <= n_pending;
            r_errors     <= n_errors;
            r_sender     <= n_sender;
            r_receiver   <= n_receiver;
            r_type       <= n_type;
            r_length     <= n_length;
            r_state      <= n_state;
            r_rd_idx     <= n_rd_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

[design/dfr_checker.sv]
// ---------------------------------------------------------------------------
// dfr_checker
// port-level checks of the delimited frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

`include "delimited_frame_receiver_defines.svh"

module dfr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [dfr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                            o_m_tuser,
    input wire logic                            o_m_tlast
);

    // a stalled result keeps its value
    `DFR_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // no new command is taken while a result waits behind a stall
    `DFR_ASSERT_IMPL(a_no_take_in_stall, o_m_tvalid && !i_m_tready, !o_s_tready)

    // a result without a data byte always ends its command
    `DFR_ASSERT_IMPL(a_single_is_last, o_m_tvalid && !o_m_tuser, o_m_tlast)

    // data bytes only come from a pending frame, header zero otherwise
    `DFR_ASSERT_IMPL(a_header_masked, o_m_tvalid && !o_m_tdata[0], !o_m_tuser && (o_m_tdata[35:6] == '0))

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (.*);

`default_nettype wire
